/* hdl/script_text_tokenizer_assert.svh */
// ----------------------------------------------------------------------------
// script_text_tokenizer_assert.svh: assertion macros
// shared property forms, clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TEXT_TOKENIZER_ASSERT_SVH
`define SCRIPT_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define STT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the script text tokenizer
// result kinds, lexer modes, character codes and the result word layout
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef enum logic [1:0] {
        KIND_CHAR         = 2'd0,
        KIND_TOKEN_END    = 2'd1,
        KIND_LINE_BREAK   = 2'd2,
        KIND_END_OF_DATA  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_SLASH        = 3'd1,
        MODE_LINE_COMMENT = 3'd2,
        MODE_BLOCK        = 3'd3,
        MODE_STAR         = 3'd4,
        MODE_QUOTED       = 3'd5,
        MODE_WORD         = 3'd6
    } t_mode;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam logic signed [15:0] BRACE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] BRACE_MIN = 16'sh8000;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_DELIMITER   = 1'b0;
    localparam t_cfg_index CFG_LINE_BREAKS = 1'b1;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         ch;
        logic [15:0]        line;
        logic [9:0]         len;
        logic               quoted;
        logic               truncated;
        logic signed [15:0] brace;
        logic               last;
    } t_result;

    localparam int GROUP_SLOTS = 3;

    // results caused by one byte, slot 0 first
    typedef struct packed {
        t_result [GROUP_SLOTS-1:0] res;
        logic [1:0]                cnt;
    } t_group;

endpackage

/* hdl/stt_in_if.sv */
// ----------------------------------------------------------------------------
// stt_in_if: text byte channel
// valid/ready handshake carrying one text byte and its end flag
// ----------------------------------------------------------------------------
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

/* hdl/stt_out_if.sv */
// ----------------------------------------------------------------------------
// stt_out_if: token result channel
// valid/ready handshake carrying one tokenizer result word
// ----------------------------------------------------------------------------
interface stt_out_if;
    logic               valid;
    logic               ready;
    stt_pkg::t_kind     result_kind;
    logic [7:0]         token_char;
    logic [15:0]        token_line;
    logic [9:0]         token_length;
    logic               token_quoted;
    logic               token_truncated;
    logic signed [15:0] brace_level;
    logic               last_of_run;

    modport source (
        output valid, result_kind, token_char, token_line, token_length,
               token_quoted, token_truncated, brace_level, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, result_kind, token_char, token_line, token_length,
               token_quoted, token_truncated, brace_level, last_of_run,
        output ready
    );
endinterface

/* hdl/script_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// script_text_tokenizer: streaming script lexer
// skips blanks and c comments, splits words and quoted strings, one byte a step
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        word
//  i_in      in   valid / ready    data_byte, end_of_data
//  o_out     out  valid / ready    one result: kind, char, line, length, flags,
//                                  brace level, last_of_run
//  i_cfg_*   in   i_cfg_we only    register index and 8-bit write data
//
//  an accepted byte waits in the input register until the slots are free, then
//  the step logic works out all its results in a single pass and loads them into
//  the slots, from where its first result is shown on o_out
//  a byte giving none or one result leaves room for the next byte every cycle
//  while o_out is ready; a byte giving more results holds the next byte back
//  until its final result leaves the slots
//  reset (synchronous, active low) returns the lexer to idle between tokens,
//  line count 1, and the registers to delimiter none, line breaks allowed
//  a stalled o_out fills the slots, then the input register, then drops ready
//
`include "script_text_tokenizer_assert.svh"

module script_text_tokenizer #(
    parameter int TOKEN_BUFFER = 1024,
    parameter int LINE_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    stt_in_if.sink              i_in,
    stt_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  stt_pkg::t_cfg_index i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    import stt_pkg::*;

    // configuration registers
    logic [7:0] r_delimiter;
    logic       r_line_breaks;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eod;

    logic       w_free;
    logic       w_step;
    t_group     w_group;

    // output side views used by the checks
    logic       w_last_out;
    logic       w_out_eod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter   <= 8'd0;
            r_line_breaks <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIMITER: begin
                    r_delimiter <= i_cfg_data;
                end
                CFG_LINE_BREAKS: begin
                    r_line_breaks <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // step when a byte waits and the slots can take its results
    assign w_step     = r_in_valid && w_free;
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_eod  <= i_in.end_of_data;
        end
    end

    // lexer state and single-pass step logic
    stt_core #(
        .TOKEN_BUFFER (TOKEN_BUFFER),
        .LINE_BITS    (LINE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte        (r_in_byte),
        .i_end         (r_in_eod),
        .i_delimiter   (r_delimiter),
        .i_line_breaks (r_line_breaks),
        .o_group       (w_group)
    );

    // result slots feeding the output channel
    stt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step),
        .i_group (w_group),
        .o_free  (w_free),
        .o_out   (o_out)
    );

    assign w_last_out = o_out.ready && o_out.last_of_run;
    assign w_out_eod  = o_out.valid && (o_out.result_kind == KIND_END_OF_DATA);

    // a waiting byte holds while the slots are busy
    `STT_ASSERT_NXT(a_in_hold, r_in_valid && !w_free, r_in_valid && $stable(r_in_byte), "byte lost")
    // a step never overwrites results still to be delivered
    `STT_ASSERT_IMP(a_step_clear, w_step, !o_out.valid || w_last_out, "step over results")
    // results of one byte come without a gap
    `STT_ASSERT_NXT(a_run_cont, o_out.valid && !o_out.last_of_run, o_out.valid, "run broken")
    // end of data is always the final result of its byte
    `STT_ASSERT_IMP(a_eod_last, w_out_eod, o_out.last_of_run, "eod not last")

endmodule

/* hdl/stt_core.sv */
// ----------------------------------------------------------------------------
// stt_core: lexer state and per-byte step logic
// holds the lexer state and works out the results of one byte in one pass
// ----------------------------------------------------------------------------
module stt_core #(
    parameter int TOKEN_BUFFER = 1024,
    parameter int LINE_BITS    = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    input  logic [7:0]      i_delimiter,
    input  logic            i_line_breaks,
    output stt_pkg::t_group o_group
);
    import stt_pkg::*;

    localparam int              LEN_W    = $clog2(TOKEN_BUFFER);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(TOKEN_BUFFER - 1);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;

    typedef struct packed {
        t_mode                mode;
        logic [LINE_BITS-1:0] line_count;
        logic [LINE_BITS-1:0] start_line;
        logic [LEN_W-1:0]     kept;
        logic [7:0]           first;
        logic                 quoted;
        logic                 truncated;
        logic signed [15:0]   brace;
    } t_lex;

    // state plus up to four raw results before the crowded-close drop
    typedef struct packed {
        t_lex          st;
        t_result [3:0] res;
        logic [2:0]    cnt;
    } t_work;

    t_lex   r_state;
    t_lex   n_state;
    t_group n_group;

    function automatic t_lex f_reset_state();
        t_lex s;
        s.mode       = MODE_IDLE;
        s.line_count = LINE_BITS'(1);
        s.start_line = '0;
        s.kept       = '0;
        s.first      = '0;
        s.quoted     = 1'b0;
        s.truncated  = 1'b0;
        s.brace      = '0;
        return s;
    endfunction

    function automatic logic [15:0] f_line16(input logic [LINE_BITS-1:0] v);
        logic [LINE_BITS+15:0] wide;
        wide = {16'd0, v};
        return (|wide[LINE_BITS+15:16]) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic logic [9:0] f_len10(input logic [LEN_W-1:0] v);
        logic [LEN_W+9:0] wide;
        wide = {10'd0, v};
        return wide[9:0];
    endfunction

    function automatic t_work f_emit(input t_work w, input t_kind kind,
                                     input logic [7:0] ch,
                                     input logic [LINE_BITS-1:0] line,
                                     input logic [LEN_W-1:0] len,
                                     input logic q, input logic t);
        t_work   o;
        t_result r;
        o           = w;
        r.kind      = kind;
        r.ch        = ch;
        r.line      = f_line16(line);
        r.len       = f_len10(len);
        r.quoted    = q;
        r.truncated = t;
        r.brace     = w.st.brace;
        r.last      = 1'b0;
        if (w.cnt < 3'd4) begin
            o.res[w.cnt[1:0]] = r;
            o.cnt             = w.cnt + 3'd1;
        end
        return o;
    endfunction

    function automatic t_work f_count_line(input t_work w);
        t_work o;
        o = w;
        if (w.st.line_count != LINE_TOP) begin
            o.st.line_count = w.st.line_count + LINE_BITS'(1);
        end
        return o;
    endfunction

    function automatic t_work f_begin(input t_work w, input logic q);
        t_work o;
        o              = w;
        o.st.start_line = w.st.line_count;
        o.st.kept      = '0;
        o.st.first     = '0;
        o.st.quoted    = q;
        o.st.truncated = 1'b0;
        return o;
    endfunction

    function automatic t_work f_keep(input t_work w, input logic [7:0] c);
        t_work o;
        o = w;
        if (w.st.kept < LEN_MAX) begin
            if (w.st.kept == '0) begin
                o.st.first = c;
            end
            o.st.kept = w.st.kept + LEN_ONE;
            o = f_emit(o, KIND_CHAR, c, o.st.start_line, o.st.kept,
                       o.st.quoted, o.st.truncated);
        end else begin
            o.st.truncated = 1'b1;
        end
        return o;
    endfunction

    function automatic t_work f_finish(input t_work w, input t_kind kind);
        t_work o;
        o = w;
        if (w.st.kept == LEN_ONE) begin
            if (w.st.first == CH_LBRACE && w.st.brace != BRACE_MAX) begin
                o.st.brace = w.st.brace + 16'sd1;
            end else if (w.st.first == CH_RBRACE && w.st.brace != BRACE_MIN) begin
                o.st.brace = w.st.brace - 16'sd1;
            end
        end
        o = f_emit(o, kind, o.st.first, o.st.start_line, o.st.kept,
                   o.st.quoted, o.st.truncated);
        o.st.mode = MODE_IDLE;
        return o;
    endfunction

    function automatic t_work f_idle(input t_work w, input logic [7:0] c,
                                     input logic allow);
        t_work o;
        o = w;
        if (c <= CH_SPACE) begin
            if (c == CH_NEWLINE) begin
                o = f_count_line(o);
                if (!allow) begin
                    o = f_emit(o, KIND_LINE_BREAK, '0, o.st.line_count, '0,
                               1'b0, 1'b0);
                end
            end
        end else if (c == CH_SLASH) begin
            o.st.mode = MODE_SLASH;
            o = f_begin(o, 1'b0);
        end else if (c == CH_QUOTE) begin
            o.st.mode = MODE_QUOTED;
            o = f_begin(o, 1'b1);
        end else begin
            o = f_begin(o, 1'b0);
            o.st.mode = MODE_WORD;
            o = f_keep(o, c);
        end
        return o;
    endfunction

    function automatic t_work f_word(input t_work w, input logic [7:0] c,
                                     input logic [7:0] delim, input logic allow);
        t_work o;
        o = w;
        if (c > CH_SPACE && c != delim) begin
            o = f_keep(o, c);
        end else begin
            o = f_finish(o, KIND_TOKEN_END);
            o = f_idle(o, c, allow);
        end
        return o;
    endfunction

    always_comb begin : p_step
        t_work w;
        w.st  = r_state;
        w.res = '0;
        w.cnt = '0;

        if (i_byte != CH_NUL) begin
            case (r_state.mode)
                MODE_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        w.st.mode = MODE_LINE_COMMENT;
                    end else if (i_byte == CH_STAR) begin
                        w.st.mode = MODE_BLOCK;
                    end else begin
                        // lone slash opens a plain word
                        w.st.mode = MODE_WORD;
                        w = f_keep(w, CH_SLASH);
                        w = f_word(w, i_byte, i_delimiter, i_line_breaks);
                    end
                end
                MODE_LINE_COMMENT: begin
                    if (i_byte == CH_NEWLINE) begin
                        w.st.mode = MODE_IDLE;
                        w = f_idle(w, i_byte, i_line_breaks);
                    end
                end
                MODE_BLOCK: begin
                    if (i_byte == CH_STAR) begin
                        w.st.mode = MODE_STAR;
                    end else if (i_byte == CH_NEWLINE) begin
                        w = f_count_line(w);
                    end
                end
                MODE_STAR: begin
                    if (i_byte == CH_SLASH) begin
                        w.st.mode = MODE_IDLE;
                    end else if (i_byte != CH_STAR) begin
                        w.st.mode = MODE_BLOCK;
                        if (i_byte == CH_NEWLINE) begin
                            w = f_count_line(w);
                        end
                    end
                end
                MODE_QUOTED: begin
                    if (i_byte == CH_QUOTE) begin
                        w = f_finish(w, KIND_TOKEN_END);
                    end else begin
                        if (i_byte == CH_NEWLINE) begin
                            w = f_count_line(w);
                        end
                        w = f_keep(w, i_byte);
                    end
                end
                MODE_WORD: begin
                    w = f_word(w, i_byte, i_delimiter, i_line_breaks);
                end
                default: begin
                    w.st.mode = MODE_IDLE;
                    w = f_idle(w, i_byte, i_line_breaks);
                end
            endcase
        end

        // stream close
        if (i_byte == CH_NUL || i_end) begin
            if (w.st.mode == MODE_WORD || w.st.mode == MODE_QUOTED) begin
                w = f_finish(w, KIND_END_OF_DATA);
            end else if (w.st.mode == MODE_SLASH) begin
                w.st.mode = MODE_WORD;
                w = f_keep(w, CH_SLASH);
                w = f_finish(w, KIND_END_OF_DATA);
            end else begin
                w = f_emit(w, KIND_END_OF_DATA, '0, '0, '0, 1'b0, 1'b0);
            end
            w.st = f_reset_state();
        end

        // crowded close: the third of four results is dropped
        if (w.cnt == 3'd4) begin
            w.res[2] = w.res[3];
            w.cnt    = 3'd3;
        end

        for (int k = 0; k < GROUP_SLOTS; k++) begin
            n_group.res[k] = w.res[k];
            if (3'(k + 1) == w.cnt) begin
                n_group.res[k].last = 1'b1;
            end
        end
        n_group.cnt = w.cnt[1:0];
        n_state     = w.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_reset_state();
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

    assign o_group = n_group;

endmodule

/* hdl/stt_outq.sv */
// ----------------------------------------------------------------------------
// stt_outq: result slot buffer
// holds the results of one byte and, while o_out is ready, hands them out one word per cycle
// ----------------------------------------------------------------------------
module stt_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  stt_pkg::t_group i_group,
    output logic            o_free,
    stt_out_if.source       o_out
);
    import stt_pkg::*;

    t_result [GROUP_SLOTS-1:0] r_slot;
    logic [1:0]                r_cnt;
    logic                      w_take;

    assign w_take = o_out.valid && o_out.ready;
    // free when empty or the final slot leaves this cycle
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_group.res;
        end else if (w_take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_out.valid           = (r_cnt != 2'd0);
    assign o_out.result_kind     = r_slot[0].kind;
    assign o_out.token_char      = r_slot[0].ch;
    assign o_out.token_line      = r_slot[0].line;
    assign o_out.token_length    = r_slot[0].len;
    assign o_out.token_quoted    = r_slot[0].quoted;
    assign o_out.token_truncated = r_slot[0].truncated;
    assign o_out.brace_level     = r_slot[0].brace;
    assign o_out.last_of_run     = r_slot[0].last;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for script_text_tokenizer
// feeds text bytes under random idling and stalls, tracks the lexer in a
// bit-exact predictor and compares every result word field by field
// ----------------------------------------------------------------------------
module tb;
    import stt_pkg::*;

    localparam int TOKEN_BUFFER  = 1024;
    localparam int KEEP_LIMIT    = TOKEN_BUFFER - 1;
    localparam int IDLE_PCT      = 17;
    localparam int SETTLE_CYCLES = 4;
    localparam int FINAL_WAIT    = 20000;
    localparam int PRINT_CAP     = 50;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    t_cfg_index cfg_index;
    logic [7:0] cfg_data;

    stt_in_if  in_ch ();
    stt_out_if out_ch ();

    script_text_tokenizer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // no idling on either side while set
    bit steady = 1'b0;

    int fail_count   = 0;
    int results_seen = 0;
    int token_bytes  = 0;

    // predictor copy of the registers
    logic [7:0] delim_char;
    logic       breaks_ok;

    // predictor copy of the lexer state
    t_mode              lex_mode;
    logic [15:0]        line_no;
    logic [15:0]        tok_line;
    logic [9:0]         tok_len;
    logic [7:0]         tok_first;
    logic               tok_quoted;
    logic               tok_cut;
    logic signed [15:0] brace_depth;

    // results of the byte being predicted, then the words still owed
    t_result step_results[$];
    t_result pending_results[$];

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor of the tokenizer
    // ------------------------------------------------------------------
    function automatic void lex_restart();
        lex_mode    = MODE_IDLE;
        line_no     = 16'd1;
        tok_line    = 16'd0;
        tok_len     = 10'd0;
        tok_first   = 8'd0;
        tok_quoted  = 1'b0;
        tok_cut     = 1'b0;
        brace_depth = 16'sd0;
    endfunction

    // word pushed with the brace depth as it stands now
    function automatic void put_result(t_kind kind, logic [7:0] ch, logic [15:0] line,
                                       logic [9:0] len, logic q, logic cut);
        t_result r;
        r.kind      = kind;
        r.ch        = ch;
        r.line      = line;
        r.len       = len;
        r.quoted    = q;
        r.truncated = cut;
        r.brace     = brace_depth;
        r.last      = 1'b0;
        if (step_results.size() < 4)
            step_results.push_back(r);
    endfunction

    // line count sticks at its top value
    function automatic void next_line();
        if (line_no != 16'hFFFF)
            line_no = line_no + 16'd1;
    endfunction

    function automatic void open_token(logic q);
        tok_line   = line_no;
        tok_len    = 10'd0;
        tok_first  = 8'd0;
        tok_quoted = q;
        tok_cut    = 1'b0;
    endfunction

    // characters past the buffer limit are dropped silently and flagged
    function automatic void keep_char(logic [7:0] c);
        if (int'(tok_len) < KEEP_LIMIT) begin
            if (tok_len == 10'd0)
                tok_first = c;
            tok_len = tok_len + 10'd1;
            put_result(KIND_CHAR, c, tok_line, tok_len, tok_quoted, tok_cut);
        end else begin
            tok_cut = 1'b1;
        end
    endfunction

    // only single-character brace tokens move the depth
    function automatic void end_token(t_kind kind);
        if (tok_len == 10'd1) begin
            if (tok_first == CH_LBRACE && brace_depth != BRACE_MAX)
                brace_depth = brace_depth + 16'sd1;
            else if (tok_first == CH_RBRACE && brace_depth != BRACE_MIN)
                brace_depth = brace_depth - 16'sd1;
        end
        put_result(kind, tok_first, tok_line, tok_len, tok_quoted, tok_cut);
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void byte_between(logic [7:0] c);
        if (c <= CH_SPACE) begin
            if (c == CH_NEWLINE) begin
                next_line();
                if (!breaks_ok)
                    put_result(KIND_LINE_BREAK, 8'd0, line_no, 10'd0, 1'b0, 1'b0);
            end
        end else if (c == CH_SLASH) begin
            lex_mode = MODE_SLASH;
            open_token(1'b0);
        end else if (c == CH_QUOTE) begin
            lex_mode = MODE_QUOTED;
            open_token(1'b1);
        end else begin
            open_token(1'b0);
            lex_mode = MODE_WORD;
            keep_char(c);
        end
    endfunction

    // the byte that ends a word is handled again as a byte between tokens
    function automatic void byte_in_word(logic [7:0] c);
        if (c > CH_SPACE && c != delim_char) begin
            keep_char(c);
        end else begin
            end_token(KIND_TOKEN_END);
            byte_between(c);
        end
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        case (lex_mode)
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    lex_mode = MODE_LINE_COMMENT;
                end else if (c == CH_STAR) begin
                    lex_mode = MODE_BLOCK;
                end else begin
                    // lone slash turns into the first character of a word
                    lex_mode = MODE_WORD;
                    keep_char(CH_SLASH);
                    byte_in_word(c);
                end
            end
            MODE_LINE_COMMENT: begin
                if (c == CH_NEWLINE) begin
                    lex_mode = MODE_IDLE;
                    byte_between(c);
                end
            end
            MODE_BLOCK: begin
                if (c == CH_STAR)
                    lex_mode = MODE_STAR;
                else if (c == CH_NEWLINE)
                    next_line();
            end
            MODE_STAR: begin
                if (c == CH_SLASH) begin
                    lex_mode = MODE_IDLE;
                end else if (c != CH_STAR) begin
                    lex_mode = MODE_BLOCK;
                    if (c == CH_NEWLINE)
                        next_line();
                end
            end
            MODE_QUOTED: begin
                if (c == CH_QUOTE) begin
                    end_token(KIND_TOKEN_END);
                end else begin
                    if (c == CH_NEWLINE)
                        next_line();
                    keep_char(c);
                end
            end
            MODE_WORD: byte_in_word(c);
            default: begin
                lex_mode = MODE_IDLE;
                byte_between(c);
            end
        endcase
    endfunction

    // an open token is closed by the end-of-data word itself
    function automatic void lex_close();
        if (lex_mode == MODE_WORD || lex_mode == MODE_QUOTED) begin
            end_token(KIND_END_OF_DATA);
        end else if (lex_mode == MODE_SLASH) begin
            lex_mode = MODE_WORD;
            keep_char(CH_SLASH);
            end_token(KIND_END_OF_DATA);
        end else begin
            put_result(KIND_END_OF_DATA, 8'd0, 16'd0, 10'd0, 1'b0, 1'b0);
        end
        lex_restart();
    endfunction

    function automatic void predict_byte(logic [7:0] c, logic eod);
        t_result tail;
        step_results.delete();
        if (c != CH_NUL)
            lex_byte(c);
        if (c == CH_NUL || eod)
            lex_close();
        // crowded close: the third of four words is left out
        if (step_results.size() == 4)
            step_results.delete(2);
        if (step_results.size() > 0) begin
            tail = step_results.pop_back();
            tail.last = 1'b1;
            step_results.push_back(tail);
        end
        foreach (step_results[k])
            pending_results.push_back(step_results[k]);
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_result(input t_result want);
        results_seen++;
        check_field("kind",      16'(out_ch.result_kind),     16'(want.kind));
        check_field("char",      16'(out_ch.token_char),      16'(want.ch));
        check_field("line",      out_ch.token_line,           want.line);
        check_field("length",    16'(out_ch.token_length),    16'(want.len));
        check_field("quoted",    16'(out_ch.token_quoted),    16'(want.quoted));
        check_field("truncated", 16'(out_ch.token_truncated), 16'(want.truncated));
        check_field("brace",     out_ch.brace_level,          want.brace);
        check_field("last",      16'(out_ch.last_of_run),     16'(want.last));
    endtask

    // every accepted result word against the oldest one owed
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0)
                report_mismatch("result word with nothing expected");
            else
                check_result(pending_results.pop_front());
        end
    end

    // result side: ready drops at random unless steady
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // one byte, with random idle cycles ahead of it, predicted on acceptance
    task automatic send_byte(input logic [7:0] c, input logic eod);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid       = 1'b1;
        in_ch.data_byte   = c;
        in_ch.end_of_data = eod;
        do @(posedge clk); while (!in_ch.ready);
        predict_byte(c, eod);
        // only bytes that do something count toward the random budget
        if (step_results.size() != 0 || lex_mode == MODE_WORD ||
            lex_mode == MODE_QUOTED || lex_mode == MODE_SLASH)
            token_bytes++;
    endtask

    task automatic send_text(input string s, input bit close_last);
        for (int k = 0; k < s.len(); k++)
            send_byte(s[k], close_last && (k == s.len() - 1));
    endtask

    // sender holds off until every owed word is out and the pipe is quiet
    task automatic settle_block();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [7:0] value);
        settle_block();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_DELIMITER)
            delim_char = value;
        else
            breaks_ok = value[0];
    endtask

    // random byte with a rare end flag
    task automatic send_rand(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 39) == 0);
    endtask

    function automatic logic [7:0] pick_break();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_NEWLINE;
            2: return (delim_char != CH_NUL) ? delim_char : CH_SPACE;
            default: return 8'($urandom_range(1, 32));
        endcase
    endfunction

    // mostly well-formed pieces of script text with random content
    task automatic send_fragment();
        int n;
        logic [7:0] b;
        n = $urandom_range(1, 5);
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                repeat (n) send_rand(8'($urandom_range(33, 255)));
                send_rand(pick_break());
            end
            3: begin
                send_rand(CH_QUOTE);
                repeat (n) begin
                    b = 8'($urandom_range(1, 255));
                    send_rand((b == CH_QUOTE) ? CH_SPACE : b);
                end
                send_rand(CH_QUOTE);
            end
            4: begin
                send_rand(CH_SLASH);
                send_rand(CH_SLASH);
                repeat (n) begin
                    b = 8'($urandom_range(1, 255));
                    send_rand((b == CH_NEWLINE) ? CH_SPACE : b);
                end
                send_rand(CH_NEWLINE);
            end
            5: begin
                send_rand(CH_SLASH);
                send_rand(CH_STAR);
                repeat (n) begin
                    case ($urandom_range(0, 3))
                        0: b = CH_STAR;
                        1: b = CH_SLASH;
                        2: b = CH_NEWLINE;
                        default: b = 8'($urandom_range(1, 255));
                    endcase
                    send_rand(b);
                end
                send_rand(CH_STAR);
                send_rand(CH_SLASH);
            end
            6: repeat (n) send_rand(pick_break());
            7: begin
                send_rand($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
                send_rand(pick_break());
            end
            8: begin
                send_rand(CH_SLASH);
                send_rand(8'($urandom_range(1, 255)));
            end
            9: send_rand(8'($urandom_range(0, 255)));
            10: send_byte(($urandom_range(0, 3) == 0) ? CH_NUL : 8'($urandom_range(1, 255)),
                          1'b1);
            default: begin
                // words split by the delimiter register
                repeat (n) send_rand(8'($urandom_range(33, 126)));
                send_rand(delim_char);
                send_rand(8'($urandom_range(33, 126)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // reset registers: brace tokens, quoted brace, high and low bytes
    task automatic test_plain_text();
        send_text("{ \"}\"", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        // close with nothing open gives an empty end-of-data word
        send_byte(CH_NUL, 1'b0);
    endtask

    // line and block comments, lone slash and open comment at close
    task automatic test_comments();
        send_text("//c\n/*\n**/", 1'b0);
        send_byte(CH_SLASH, 1'b1);
        send_text("/*", 1'b1);
    endtask

    // quoted newline closed by a zero byte, then an empty quoted string
    task automatic test_quoted();
        send_text("\"\n", 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_text("\"\"", 1'b0);
    endtask

    // markers per skipped newline and the crowded close cases
    task automatic test_line_markers();
        write_reg(CFG_LINE_BREAKS, 8'd0);
        write_reg(CFG_DELIMITER, ",");
        send_text("\na,b", 1'b1);
        send_text("/\n", 1'b1);
        send_text("/,", 1'b1);
    endtask

    // three phases of random text over register extremes, the middle one
    // with no idling on either side
    task automatic test_random_text();
        logic [7:0] delims [3];
        logic       breaks [3];
        delims = '{8'hFF, 8'($urandom_range(33, 126)), 8'h00};
        breaks = '{1'b0, 1'b1, 1'b0};
        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_DELIMITER, delims[p]);
            write_reg(CFG_LINE_BREAKS, 8'(breaks[p]));
            token_bytes = 0;
            steady = (p == 1);
            while (token_bytes < 28)
                send_fragment();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_DELIMITER;
        cfg_data          = 8'd0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = 8'd0;
        in_ch.end_of_data = 1'b0;
        delim_char        = 8'd0;
        breaks_ok         = 1'b1;
        lex_restart();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_plain_text();
        test_comments();
        test_quoted();
        test_line_markers();
        test_random_text();

        // drain, then give the pipe time to show any stray word
        @(negedge clk);
        in_ch.valid = 1'b0;
        for (int n = 0; n < FINAL_WAIT && pending_results.size() != 0; n++)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
        if (fail_count == 0)
            $display("script_text_tokenizer test passed");
        else
            $display("script_text_tokenizer test failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #(1_000_000);
        $display("script_text_tokenizer test failed");
        $finish;
    end

endmodule

/* script_text_tokenizer.f */
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_in_if.sv
hdl/stt_out_if.sv
hdl/stt_core.sv
hdl/stt_outq.sv
hdl/script_text_tokenizer.sv
tb/sv/tb.sv
